>>> design/tifc_pkg.sv
// Package with the character codes and shared types of the meter-link frame checker.
`default_nettype none

package tifc_pkg;

   localparam int CHAR_WIDTH = 7;
   localparam int SUM_WIDTH  = 6;

   localparam logic [CHAR_WIDTH-1:0] CHAR_NUL = 7'h00;
   localparam logic [CHAR_WIDTH-1:0] CHAR_STX = 7'h02;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ETX = 7'h03;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LF  = 7'h0A;
   localparam logic [CHAR_WIDTH-1:0] CHAR_CR  = 7'h0D;
   localparam logic [CHAR_WIDTH-1:0] SUM_BIAS = 7'h20;

   localparam logic [1:0] GROUP_LEN_FULL = 2'd2;

   typedef struct packed {
      logic                  frame_active;
      logic                  prev_was_etx;
      logic [SUM_WIDTH-1:0]  group_sum;
      logic [CHAR_WIDTH-1:0] last_char;
      logic [CHAR_WIDTH-1:0] prior_char;
      logic [1:0]            group_len;
      logic                  groups_seen;
      logic                  group_failed;
   } state_type;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] data_char;
      logic                  char_stored;
      logic                  in_frame;
      logic                  group_done;
      logic                  group_ok;
      logic                  frame_done;
      logic                  frame_ok;
   } result_type;

   localparam state_type STATE_RESET = '{
      frame_active: 1'b0,
      prev_was_etx: 1'b0,
      group_sum:    '0,
      last_char:    '0,
      prior_char:   '0,
      group_len:    2'd0,
      groups_seen:  1'b0,
      group_failed: 1'b0
   };

endpackage

`default_nettype wire

>>> design/tifc_step.sv
// Next-state and result logic for one received character of the frame checker.
`default_nettype none

module tifc_step (
   input  wire logic [7:0]          rx_byte,
   input  wire tifc_pkg::state_type state_cur,
   output tifc_pkg::state_type      state_nxt,
   output tifc_pkg::result_type     result
);

   logic [tifc_pkg::CHAR_WIDTH-1:0] c;
   logic [tifc_pkg::CHAR_WIDTH-1:0] expect_char;
   logic                            group_full;
   logic                            sum_match;

   assign c           = rx_byte[6:0];
   assign group_full  = (state_cur.group_len == tifc_pkg::GROUP_LEN_FULL);
   assign expect_char = {1'b0, state_cur.group_sum} + tifc_pkg::SUM_BIAS;
   assign sum_match   = group_full && (expect_char == state_cur.last_char);

   always_comb begin
      state_nxt          = state_cur;
      result.data_char   = c;
      result.char_stored = 1'b0;
      result.group_done  = 1'b0;
      result.group_ok    = 1'b0;
      result.frame_done  = 1'b0;
      result.frame_ok    = 1'b0;

      if (!state_cur.frame_active) begin
         if ((c == tifc_pkg::CHAR_STX) && state_cur.prev_was_etx) begin
            state_nxt              = tifc_pkg::STATE_RESET;
            state_nxt.frame_active = 1'b1;
         end else begin
            state_nxt.prev_was_etx = (c == tifc_pkg::CHAR_ETX);
         end
      end else if (c == tifc_pkg::CHAR_ETX) begin
         result.frame_done = 1'b1;
         result.frame_ok   = state_cur.groups_seen && !state_cur.group_failed;
         state_nxt         = tifc_pkg::STATE_RESET;
      end else if (c != tifc_pkg::CHAR_NUL) begin
         result.char_stored = 1'b1;
         if (c == tifc_pkg::CHAR_CR) begin
            result.group_done      = 1'b1;
            result.group_ok        = sum_match;
            state_nxt.groups_seen  = 1'b1;
            state_nxt.group_failed = state_cur.group_failed || !sum_match;
            state_nxt.group_sum    = '0;
            state_nxt.last_char    = '0;
            state_nxt.prior_char   = '0;
            state_nxt.group_len    = 2'd0;
         end else if (c != tifc_pkg::CHAR_LF) begin
            if (group_full) begin
               state_nxt.group_sum = state_cur.group_sum
                                     + state_cur.prior_char[tifc_pkg::SUM_WIDTH-1:0];
            end else begin
               state_nxt.group_len = state_cur.group_len + 2'd1;
            end
            state_nxt.prior_char = state_cur.last_char;
            state_nxt.last_char  = c;
         end
      end

      result.in_frame = state_nxt.frame_active;
   end

endmodule

`default_nettype wire

>>> design/teleinfo_frame_checker_unit.sv
// Top level of the meter-link frame checker: input register, checker state and result register.
`default_nettype none

// The unit takes one received byte per item, clears its parity bit and tracks
// frames and groups of the historic meter-link format, giving exactly one result
// item per input item. A byte is captured in an input register when it is
// accepted, and the checker state and the result register are updated from it
// once the result register is free, so an item passes the input register and
// the result register on its way to the result port. One item is taken every
// cycle as long as the result side keeps taking results; the group checksum
// state is updated combinationally from each byte and does not limit that rate.
module teleinfo_frame_checker_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   input  wire logic [7:0] req_rx_byte,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   output      logic [6:0] rsp_data_char,
   output      logic       rsp_char_stored,
   output      logic       rsp_in_frame,
   output      logic       rsp_group_done,
   output      logic       rsp_group_ok,
   output      logic       rsp_frame_done,
   output      logic       rsp_frame_ok
);

   logic                 in_valid_ff;
   logic                 in_valid_in;
   logic [7:0]           in_byte_ff;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   tifc_pkg::result_type out_result_ff;
   tifc_pkg::state_type  state_ff;
   tifc_pkg::state_type  state_in;
   tifc_pkg::result_type step_result;
   logic                 out_free;
   logic                 advance;

   assign out_free     = !out_valid_ff || rsp_ready;
   assign advance      = in_valid_ff && out_free;
   assign req_ready    = !in_valid_ff || advance;
   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   tifc_step u_step (
      .rx_byte   (in_byte_ff),
      .state_cur (state_ff),
      .state_nxt (state_in),
      .result    (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= tifc_pkg::STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance) begin
         out_result_ff <= step_result;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_data_char   = out_result_ff.data_char;
   assign rsp_char_stored = out_result_ff.char_stored;
   assign rsp_in_frame    = out_result_ff.in_frame;
   assign rsp_group_done  = out_result_ff.group_done;
   assign rsp_group_ok    = out_result_ff.group_ok;
   assign rsp_frame_done  = out_result_ff.frame_done;
   assign rsp_frame_ok    = out_result_ff.frame_ok;

`ifndef SYNTHESIS
   a_group_ok_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_group_ok |-> rsp_group_done)
      else $error("Group reported good without a closed group.");

   a_group_inside_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_group_done |-> rsp_in_frame && rsp_char_stored)
      else $error("Group closed outside a frame.");

   a_frame_end_leaves_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> !rsp_in_frame && !rsp_char_stored)
      else $error("Frame end left the checker inside a frame.");

   a_state_holds_when_stalled: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("Checker state changed without a processed item.");
`endif

endmodule

`default_nettype wire
